[rtl/source_line_classifier_core_macros.svh]
// Assertion macros shared by the source line classifier RTL.
`ifndef SOURCE_LINE_CLASSIFIER_CORE_MACROS_SVH
`define SOURCE_LINE_CLASSIFIER_CORE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define SLC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SLC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

[rtl/slc_pkg.sv]
// Types and constants shared by the source line classifier modules.
`default_nettype none
package slc_pkg;

   typedef enum logic {
      OP_CHAR = 1'b0,
      OP_EOL  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CLASS_BLANK   = 2'd0,
      CLASS_COMMENT = 2'd1,
      CLASS_CODE    = 2'd2
   } line_class_type;

   // What one processed transaction contributes to the running totals.
   typedef struct packed {
      logic           char_step;
      logic           line_step;
      line_class_type line_class;
   } tally_type;

   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;

   localparam int RSP_COUNT_WIDTH = 32;
   localparam int TOTAL_COUNT     = 4;
   localparam int TOT_LINES       = 0;
   localparam int TOT_CHARS       = 1;
   localparam int TOT_COMMENT     = 2;
   localparam int TOT_CODE        = 3;

   function automatic logic is_space(input logic [7:0] b);
      return b inside {8'h20, [8'h09:8'h0D]};
   endfunction

endpackage
`default_nettype wire

[rtl/slc_line_state.sv]
// Per-line prefix, close-marker tracking, block-comment flag and line classification.
`default_nettype none
module slc_line_state
   import slc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_valid,
   input  op_type     step_op,
   input  logic [7:0] step_byte,
   output tally_type  tally
);

   localparam logic [1:0] PREFIX_EMPTY = 2'd0;
   localparam logic [1:0] PREFIX_FIRST = 2'd1;
   localparam logic [1:0] PREFIX_FULL  = 2'd2;

   logic       in_block_ff, in_block_in;
   logic [1:0] prefix_ff, prefix_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic [7:0] prev_ff, prev_in;
   logic       close_ff, close_in;

   line_class_type line_class;
   logic           block_after;
   logic           starts_slash;

   always_comb begin
      starts_slash = (prefix_ff == PREFIX_FULL) && (first_ff == CHAR_SLASH);
      block_after  = in_block_ff;
      if (prefix_ff == PREFIX_EMPTY) begin
         line_class = CLASS_BLANK;
      end else if (in_block_ff) begin
         line_class  = CLASS_COMMENT;
         block_after = !close_ff;
      end else if (starts_slash && second_ff == CHAR_SLASH) begin
         line_class = CLASS_COMMENT;
      end else if (starts_slash && second_ff == CHAR_STAR) begin
         // A closing marker on the opening line, even an overlapping one, keeps the block shut.
         line_class  = CLASS_COMMENT;
         block_after = !close_ff;
      end else begin
         line_class = CLASS_CODE;
      end
   end

   assign tally.char_step  = step_valid && (step_op == OP_CHAR);
   assign tally.line_step  = step_valid && (step_op == OP_EOL);
   assign tally.line_class = line_class;

   always_comb begin
      in_block_in = in_block_ff;
      prefix_in   = prefix_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      prev_in     = prev_ff;
      close_in    = close_ff;
      if (tally.char_step) begin
         if (prev_ff == CHAR_STAR && step_byte == CHAR_SLASH) begin
            close_in = 1'b1;
         end
         case (prefix_ff)
            PREFIX_EMPTY: begin
               if (!is_space(step_byte)) begin
                  first_in  = step_byte;
                  prefix_in = PREFIX_FIRST;
               end
            end
            PREFIX_FIRST: begin
               second_in = step_byte;
               prefix_in = PREFIX_FULL;
            end
            default: begin
            end
         endcase
         prev_in = step_byte;
      end else if (tally.line_step) begin
         in_block_in = block_after;
         prefix_in   = PREFIX_EMPTY;
         first_in    = 8'h00;
         second_in   = 8'h00;
         prev_in     = 8'h00;
         close_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_block_ff <= 1'b0;
         prefix_ff   <= PREFIX_EMPTY;
         first_ff    <= 8'h00;
         second_ff   <= 8'h00;
         prev_ff     <= 8'h00;
         close_ff    <= 1'b0;
      end else begin
         in_block_ff <= in_block_in;
         prefix_ff   <= prefix_in;
         first_ff    <= first_in;
         second_ff   <= second_in;
         prev_ff     <= prev_in;
         close_ff    <= close_in;
      end
   end

endmodule
`default_nettype wire

[rtl/slc_totals.sv]
// Saturating running totals of lines, bytes, comment lines and code lines.
`default_nettype none
module slc_totals
   import slc_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  tally_type                                tally,
   output logic [TOTAL_COUNT-1:0][COUNT_WIDTH-1:0] count_in
);

   logic [TOTAL_COUNT-1:0][COUNT_WIDTH-1:0] count_ff;

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (&v) ? v : v + COUNT_WIDTH'(1);
   endfunction

   always_comb begin
      count_in = count_ff;
      if (tally.char_step) begin
         count_in[TOT_CHARS] = sat_inc(count_ff[TOT_CHARS]);
      end
      if (tally.line_step) begin
         count_in[TOT_LINES] = sat_inc(count_ff[TOT_LINES]);
         if (tally.line_class == CLASS_COMMENT) begin
            count_in[TOT_COMMENT] = sat_inc(count_ff[TOT_COMMENT]);
         end else if (tally.line_class == CLASS_CODE) begin
            count_in[TOT_CODE] = sat_inc(count_ff[TOT_CODE]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

[rtl/source_line_classifier_core.sv]
// Top level of the source line classifier: input register, line tracker, totals, result register.
`default_nettype none
`include "source_line_classifier_core_macros.svh"
// The block takes one transaction per clock cycle, character or end of line alike, and
// sustains that rate as long as results are taken; a character transaction never waits
// for the result side. An end-of-line transaction passes through the input register, and
// its result is caught in the result register together with the update of the line
// state and the saturating totals. The totals are COUNT_WIDTH bits wide and saturate there;
// each total leaves the block as 32 bits: its low 32 bits, or zero-extended if narrower.
module source_line_classifier_core
   import slc_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] char_byte
   input  logic         req_tuser,   // [0] operation
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [31:0] total_lines, [63:32] total_characters,
                                     // [95:64] comment_line_count, [127:96] code_line_count
   output logic [1:0]   rsp_tuser    // [1:0] line_class
);

   logic       in_valid_ff, in_valid_in;
   op_type     in_op_ff;
   logic [7:0] in_byte_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   line_class_type rsp_class_ff;
   logic [TOTAL_COUNT-1:0][RSP_COUNT_WIDTH-1:0] rsp_data_ff;

   logic      req_accept;
   logic      process;
   logic      process_eol;
   tally_type tally;

   logic [TOTAL_COUNT-1:0][COUNT_WIDTH-1:0]     count_in;
   logic [TOTAL_COUNT-1:0][RSP_COUNT_WIDTH-1:0] count_out;

   // A character transaction needs no result slot, so only end of line waits for one.
   assign process     = in_valid_ff && (in_op_ff == OP_CHAR || !rsp_valid_ff || rsp_tready);
   assign process_eol = process && (in_op_ff == OP_EOL);
   assign req_tready  = !in_valid_ff || process;
   assign req_accept  = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (process_eol) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff   <= op_type'(req_tuser);
         in_byte_ff <= req_tdata;
      end
      if (process_eol) begin
         rsp_class_ff <= tally.line_class;
         rsp_data_ff  <= count_out;
      end
   end

   slc_line_state u_line_state (
      .clock      (clock),
      .reset      (reset),
      .step_valid (process),
      .step_op    (in_op_ff),
      .step_byte  (in_byte_ff),
      .tally      (tally)
   );

   slc_totals #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_totals (
      .clock    (clock),
      .reset    (reset),
      .tally    (tally),
      .count_in (count_in)
   );

   for (genvar i = 0; i < TOTAL_COUNT; i++) begin : g_count_out
      if (COUNT_WIDTH >= RSP_COUNT_WIDTH) begin : g_trunc
         assign count_out[i] = count_in[i][RSP_COUNT_WIDTH-1:0];
      end else begin : g_ext
         assign count_out[i] = {{(RSP_COUNT_WIDTH-COUNT_WIDTH){1'b0}}, count_in[i]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_class_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SLC_ASSERT_NEXT(a_eol_gives_result, process_eol, rsp_valid_ff,
      "end-of-line transaction did not produce a result")
   `SLC_ASSERT_NEXT(a_char_no_result, !rsp_valid_ff && process && in_op_ff == OP_CHAR,
      !rsp_valid_ff, "character transaction produced a result")
   `SLC_ASSERT_NOW(a_lines_nonzero, rsp_valid_ff, rsp_data_ff[TOT_LINES] != '0,
      "result shows a zero line total")
   `SLC_ASSERT_NOW(a_comment_counted, rsp_valid_ff && rsp_class_ff == CLASS_COMMENT,
      rsp_data_ff[TOT_COMMENT] != '0, "comment line result with zero comment total")

endmodule
`default_nettype wire
